### src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window median filter
// Field widths and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 11;

    // controller -> datapath commands
    typedef struct packed {
        logic clr_run;    // write zero at the clear address, advance it
        logic accept;     // capture a request, read the oldest ring slot
        logic fetch;      // store sample in ring, update fill/pointer, load a tree walk
        logic chain_run;  // run one level of the tree update walk
        logic load_ins;   // load the insertion walk
        logic load_srch;  // start the rank search
        logic srch_rd;    // search: read the candidate node
        logic srch_cmp;   // search: compare and descend
        logic out_load;   // move the median into the output register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic cfg_wr;      // window size written this cycle
        logic clr_last;    // clear address at the last tree entry
        logic full;        // window holds all its samples
        logic chain_done;  // tree update walk finished
        logic emit;        // window full after this sample
        logic step_zero;   // search has run all levels
        logic nxt_ok;      // candidate node is inside the tree
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

`default_nettype wire

### src/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median: running lower median over the last W samples
// Ring of samples plus a Fenwick tree of value counts; the median of rank
// (W+1)/2 is found by binary lifting over the tree.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   sample [15:0]
//  m_axis    out        m_axis_tvalid/m_axis_tready   median [15:0]
//  cfg       in         i_cfg_valid/o_cfg_ready       window_size [10:0]
//
//  One request at a time: ring access, then tree removal, tree insertion and
//  the rank search. Each tree walk touches at most L = clog2(VALUE_RANGE+1)
//  = 17 Fenwick levels at the default. Removal applies once the window is
//  full, the search and the output load only when a median is due.
//  Reset and every window write clear all VALUE_RANGE tree entries (65536
//  at the default); the output register lets the next request start.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median #(
    parameter int VALUE_RANGE = 65536,
    parameter int WINDOW_MAX  = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input samples
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
    // output medians
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [swm_pkg::SAMPLE_W-1:0] m_axis_tdata,   // [15:0] median
    // window size register
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]    i_cfg_data      // [10:0] window_size
);

    import swm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    swm_dp #(
        .VALUE_RANGE (VALUE_RANGE),
        .WINDOW_MAX  (WINDOW_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_median    (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

### src/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer of the sliding window median filter
// Walks each request through ring access, tree removal, tree insertion and
// the rank search; runs the clearing pass after reset and window writes.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd      o_cmd
);

    import swm_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_FETCH    = 7'b0000100,
        S_REMOVE   = 7'b0001000,
        S_INSERT   = 7'b0010000,
        S_SRCH_RD  = 7'b0100000,
        S_SRCH_CMP = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_run = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                // a window write in the same cycle takes precedence
                o_in_ready = !i_sts.cfg_wr;
                if (i_in_valid && !i_sts.cfg_wr) begin
                    cmd.accept = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
                n_state   = i_sts.full ? S_REMOVE : S_INSERT;
            end
            S_REMOVE: begin
                cmd.chain_run = 1'b1;
                if (i_sts.chain_done) begin
                    cmd.load_ins = 1'b1;
                    n_state      = S_INSERT;
                end
            end
            S_INSERT: begin
                cmd.chain_run = 1'b1;
                if (i_sts.chain_done) begin
                    if (i_sts.emit) begin
                        cmd.load_srch = 1'b1;
                        n_state       = S_SRCH_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SRCH_RD: begin
                if (i_sts.step_zero) begin
                    // wait for room in the output register
                    if (i_sts.out_free) begin
                        cmd.out_load = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.srch_rd = 1'b1;
                    if (i_sts.nxt_ok) n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                cmd.srch_cmp = 1'b1;
                n_state      = S_SRCH_RD;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // a window write restarts from an empty window
        if (i_sts.cfg_wr) n_state = S_CLEAR;
    end

    assign o_cmd = cmd;

    // requests are taken only when the tree is consistent
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_sts.cfg_wr) |=> (r_state == S_FETCH))
        else $error("accepted request did not start processing");

    // the clearing pass ends only at the last tree entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_CLEAR) && (r_state == S_IDLE)) |-> $past(i_sts.clr_last))
        else $error("clearing pass left early");

    // a search result is never produced for a window that is not full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_srch |-> i_sts.emit)
        else $error("search started on a partial window");

endmodule

`default_nettype wire

### src/swm_dp.sv
// ----------------------------------------------------------------------------
// swm_dp: datapath of the sliding window median filter
// Sample ring, Fenwick count tree, tree walk and rank search registers,
// window configuration and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_dp #(
    parameter int VALUE_RANGE = 65536,
    parameter int WINDOW_MAX  = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [swm_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic      [swm_pkg::SAMPLE_W-1:0]  o_median,
    input  wire swm_pkg::t_cmd                 i_cmd,
    output swm_pkg::t_sts                      o_sts
);

    import swm_pkg::*;

    localparam int TAW    = $clog2(VALUE_RANGE);      // tree address bits
    localparam int IW     = TAW + 2;                  // tree index incl. overflow
    localparam int LEVELS = $clog2(VALUE_RANGE + 1);  // search levels
    localparam int RAW    = $clog2(WINDOW_MAX);       // ring address bits
    localparam int WW     = $clog2(WINDOW_MAX + 1);   // window size and counts

    localparam logic [IW-1:0]       VR_IDX     = IW'(VALUE_RANGE);
    localparam logic [IW-1:0]       TOP_STEP   = IW'(1) << (LEVELS - 1);
    localparam logic [TAW-1:0]      CLR_LAST   = TAW'(VALUE_RANGE - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(VALUE_RANGE - 1);
    localparam logic [31:0]         WMAX_32    = 32'(WINDOW_MAX);

    // registers
    logic [CFG_W-1:0]    r_cfg;
    logic [WW-1:0]       r_fill;
    logic [RAW-1:0]      r_ptr;
    logic [TAW-1:0]      r_clr;
    logic [RAW-1:0]      r_p;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_dec;
    logic [IW-1:0]       r_idx;
    logic [TAW-1:0]      r_waddr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_pos;
    logic [IW-1:0]       r_step;
    logic [WW-1:0]       r_rank;
    logic [IW-1:0]       r_nxt;
    logic                r_out_vld;
    logic [SAMPLE_W-1:0] r_median;

    // combinational
    logic [WW-1:0]       w_eff;
    logic [SAMPLE_W-1:0] s_sat;
    logic [RAW-1:0]      p_cur;
    logic [WW-1:0]       p_inc;
    logic                full;
    logic                idx_ok;
    logic [IW-1:0]       lowbit;
    logic [IW-1:0]       nxt;
    logic                nxt_ok;
    logic [WW:0]         rank_sum;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                tree_we;
    logic [TAW-1:0]      tree_waddr;
    logic [WW-1:0]       tree_wdata;
    logic                tree_re;
    logic [TAW-1:0]      tree_raddr;
    logic [WW-1:0]       tree_rdata;

    // effective window: zero reads as one, saturate at the ring depth
    always_comb begin
        if (r_cfg == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg) > WMAX_32) begin
            w_eff = WW'(WINDOW_MAX);
        end else begin
            w_eff = WW'(r_cfg);
        end
    end

    assign s_sat    = (i_sample > SAMPLE_MAX) ? SAMPLE_MAX : i_sample;
    assign p_cur    = (WW'(r_ptr) >= w_eff) ? '0 : r_ptr;
    assign p_inc    = WW'(r_p) + WW'(1);
    assign full     = (r_fill >= w_eff);
    assign idx_ok   = (r_idx <= VR_IDX);
    assign lowbit   = r_idx & (~r_idx + IW'(1));
    assign nxt      = r_pos + r_step;
    assign nxt_ok   = (nxt <= VR_IDX);
    assign rank_sum = {1'b0, w_eff} + (WW + 1)'(1);

    // window configuration, fill count and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_W'(1);
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (i_cfg_valid) begin
            r_cfg  <= i_cfg_data;
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (i_cmd.fetch) begin
            r_fill <= full ? w_eff : r_fill + WW'(1);
            r_ptr  <= (p_inc >= w_eff) ? '0 : RAW'(p_inc);
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cfg_valid) begin
            r_clr <= '0;
        end else if (i_cmd.clr_run) begin
            r_clr <= r_clr + TAW'(1);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= s_sat;
            r_p      <= p_cur;
        end
    end

    // tree update walk: read next node while writing the previous one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.chain_run && idx_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_dec <= full;
            r_idx <= full ? IW'(ring_rdata) + IW'(1) : IW'(r_sample) + IW'(1);
        end else if (i_cmd.load_ins) begin
            r_dec <= 1'b0;
            r_idx <= IW'(r_sample) + IW'(1);
        end else if (i_cmd.chain_run && idx_ok) begin
            r_idx   <= r_idx + lowbit;
            r_waddr <= TAW'(r_idx - IW'(1));
        end
    end

    // rank search by binary lifting
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_srch) begin
            r_pos  <= '0;
            r_step <= TOP_STEP;
            r_rank <= WW'(rank_sum >> 1);
        end else if (i_cmd.srch_rd) begin
            if (nxt_ok) begin
                r_nxt <= nxt;
            end else begin
                r_step <= r_step >> 1;
            end
        end else if (i_cmd.srch_cmp) begin
            if (tree_rdata < r_rank) begin
                r_pos  <= r_nxt;
                r_rank <= r_rank - tree_rdata;
            end
            r_step <= r_step >> 1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_median <= SAMPLE_W'(r_pos);
        end
    end

    // tree memory port selection
    assign tree_we    = i_cmd.clr_run || (i_cmd.chain_run && r_rd_vld);
    assign tree_waddr = i_cmd.clr_run ? r_clr : r_waddr;
    assign tree_wdata = i_cmd.clr_run ? '0
                      : (r_dec ? tree_rdata - WW'(1) : tree_rdata + WW'(1));
    assign tree_re    = (i_cmd.chain_run && idx_ok) || (i_cmd.srch_rd && nxt_ok);
    assign tree_raddr = i_cmd.chain_run ? TAW'(r_idx - IW'(1)) : TAW'(nxt - IW'(1));

    // Fenwick count tree, node i at address i-1
    swm_ram #(
        .WIDTH (WW),
        .DEPTH (VALUE_RANGE)
    ) u_tree (
        .i_clk     (i_clk),
        .i_wr_en   (tree_we),
        .i_wr_addr (tree_waddr),
        .i_wr_data (tree_wdata),
        .i_rd_en   (tree_re),
        .i_rd_addr (tree_raddr),
        .o_rd_data (tree_rdata)
    );

    // sample ring
    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.fetch),
        .i_wr_addr (r_p),
        .i_wr_data (r_sample),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (p_cur),
        .o_rd_data (ring_rdata)
    );

    // status
    always_comb begin
        o_sts            = '0;
        o_sts.cfg_wr     = i_cfg_valid;
        o_sts.clr_last   = (r_clr == CLR_LAST);
        o_sts.full       = full;
        o_sts.chain_done = !r_rd_vld && !idx_ok;
        o_sts.emit       = (r_fill == w_eff);
        o_sts.step_zero  = (r_step == '0);
        o_sts.nxt_ok     = nxt_ok;
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_median    = r_median;

    // fill count stays within the window
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill count above window size");

    // no read and write of the same tree node in one cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tree_we && tree_re) |-> (tree_waddr != tree_raddr))
        else $error("tree read and write collide");

    // removal never takes a count below zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.chain_run && r_rd_vld && r_dec) |-> (tree_rdata != '0))
        else $error("tree count underflow on removal");

    // remaining rank is at least one through the search
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srch_cmp |-> (r_rank != '0))
        else $error("search rank reached zero");

    // a result never overwrites one still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("output register overrun");

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the sliding window median filter
// Drives samples and window size writes through the stream and config
// channels with random idle cycles and stalls on both sides, predicts each
// lower median from a sorted copy of the window, and checks every median
// the block returns, in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Predicts the lower median of the most recent samples. The window is held
// twice: as a ring in arrival order and as a sorted list for the rank lookup.
class window_median_calc;

    int unsigned                   win_max = 1024;
    logic [swm_pkg::SAMPLE_W-1:0]  ring [1024];
    logic [swm_pkg::SAMPLE_W-1:0]  ordered [1024];
    int unsigned                   held;
    int unsigned                   next_slot;
    int unsigned                   span;
    logic [swm_pkg::SAMPLE_W-1:0]  medians_due [$];

    function new();
        set_window(11'd1);
    endfunction

    // any write empties the window; zero acts as one, large sizes saturate
    function void set_window(input logic [swm_pkg::CFG_W-1:0] size);
        if (size == 0) begin
            span = 1;
        end else if (size > win_max) begin
            span = win_max;
        end else begin
            span = size;
        end
        held      = 0;
        next_slot = 0;
    endfunction

    function void note_sample(input logic [swm_pkg::SAMPLE_W-1:0] value);
        int unsigned                  idx;
        logic [swm_pkg::SAMPLE_W-1:0] gone;
        // full window: drop the oldest sample from the sorted list
        if (held >= span) begin
            gone = ring[next_slot];
            idx  = 0;
            while (ordered[idx] != gone) idx++;
            while (idx + 1 < held) begin
                ordered[idx] = ordered[idx + 1];
                idx++;
            end
            held--;
        end
        ring[next_slot] = value;
        // insertion keeps the list ascending
        idx = held;
        while (idx > 0 && ordered[idx - 1] > value) begin
            ordered[idx] = ordered[idx - 1];
            idx--;
        end
        ordered[idx] = value;
        held++;
        next_slot = (next_slot + 1 >= span) ? 0 : next_slot + 1;
        // rank (W+1)/2, one-based
        if (held == span) medians_due.push_back(ordered[(span + 1) / 2 - 1]);
    endfunction

    function bit check_median(input  logic [swm_pkg::SAMPLE_W-1:0] got,
                              output logic [swm_pkg::SAMPLE_W-1:0] want,
                              output bit                           orphan);
        orphan = (medians_due.size() == 0);
        want   = '0;
        if (orphan) return 0;
        want = medians_due.pop_front();
        return got === want;
    endfunction

    function int pending();
        return medians_due.size();
    endfunction

    function void drop_pending();
        medians_due.delete();
    endfunction

endclass

module tb_top;

    localparam int STEP_LATENCY = 100;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TIMEOUT      = 40_000_000;
    localparam int MAX_PRINTS   = 100;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [swm_pkg::SAMPLE_W-1:0] m_axis_tdata;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [swm_pkg::CFG_W-1:0]    i_cfg_data;

    window_median_calc calc;
    int  mismatch_count;
    bit  src_no_wait;
    bit  snk_no_wait;
    int  hold_asked;
    int  hold_seen;
    int  hold_left;
    int  wait_left;
    bit  took_median;

    sliding_window_median DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT;
        $display("tb_top failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // median checker, sampled at the rising edge
    always @(posedge i_clk) begin : median_check
        logic [swm_pkg::SAMPLE_W-1:0] want;
        bit                           orphan;
        took_median <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (!calc.check_median(m_axis_tdata, want, orphan)) begin
                if (orphan) begin
                    report_mismatch($sformatf("median %0d with none expected", m_axis_tdata));
                end else begin
                    report_mismatch($sformatf("median %0d, expected %0d", m_axis_tdata, want));
                end
            end
        end
    end

    // result side ready: random waits per request, plus a long hold on demand
    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (took_median) wait_left = snk_no_wait ? 0 : $urandom_range(0, 10);
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (wait_left > 0) begin
            wait_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // leaves tvalid high; a gap before the next request or a drain lowers it
    task automatic send_sample(input logic [swm_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = src_no_wait ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            @(negedge i_clk) s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        calc.note_sample(value);
    endtask

    // stop offering, wait for every median, then let the last request finish
    task automatic drain();
        int waited;
        waited = 0;
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (calc.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (calc.pending() != 0) begin
            report_mismatch($sformatf("%0d medians never arrived", calc.pending()));
            calc.drop_pending();
        end
        repeat (STEP_LATENCY) @(posedge i_clk);
    endtask

    task automatic set_window_size(input logic [swm_pkg::CFG_W-1:0] size);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        calc.set_window(size);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // mix of full range, tight clusters with ties, and the extremes
    function automatic logic [swm_pkg::SAMPLE_W-1:0] pick_sample();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 4) return 16'($urandom_range(0, 65535));
        if (kind <= 7) return 16'($urandom_range(0, 15));
        if (kind == 8) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(32766, 32769));
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                src_no_wait = ($urandom_range(0, 3) == 0);
                snk_no_wait = ($urandom_range(0, 3) == 0);
            end
            send_sample(pick_sample());
        end
    endtask

    initial begin
        calc           = new();
        mismatch_count = 0;
        src_no_wait    = 1'b0;
        snk_no_wait    = 1'b0;
        hold_asked     = 0;
        hold_seen      = 0;
        hold_left      = 0;
        wait_left      = 0;
        took_median    = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset window of one: every sample is its own median
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0001);

        // size zero behaves as one
        set_window_size(11'd0);
        send_sample(16'hFFFE);
        send_sample(16'h0002);

        // back-to-back requests against a held-off result side
        src_no_wait = 1'b1;
        hold_asked++;
        for (int k = 0; k < 30; k++) send_sample(pick_sample());
        src_no_wait = 1'b0;

        // even window: lower median is the smaller of two
        set_window_size(11'd2);
        send_sample(16'd300);
        send_sample(16'd100);
        send_sample(16'd100);
        send_sample(16'hFFFF);
        send_sample(16'h0000);

        // odd window with repeated values
        set_window_size(11'd3);
        send_sample(16'd7);
        send_sample(16'd7);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'd7);
        send_sample(16'hFFFF);

        // mid-size window, with one full pause for the results halfway
        set_window_size(11'($urandom_range(4, 64)));
        send_random(300);
        drain();
        send_random(300);

        // oversize write saturates to the largest window
        set_window_size(11'h7FF);
        send_random(1100);

        drain();
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
